@@ rtl/core/nbss_pkg.sv @@
// shared types and codes of the nested break-site stack
`timescale 1ns / 1ps

package nbss_pkg;

  typedef enum logic [1:0] {
    CMD_ENTER  = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_EXIT   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_LEVEL  = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_t;

  localparam int unsigned SITE_W  = 16;
  localparam int unsigned DEPTH_W = 4;

  typedef struct packed {
    logic [1:0]        command;
    logic [SITE_W-1:0] break_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               site_valid;
    logic [SITE_W-1:0]  patch_site;
    logic               last;
    logic               in_loop;
    logic [DEPTH_W-1:0] level_depth;
  } out_item_t;

endpackage

@@ rtl/core/nbss_ram.sv @@
// single-port-write, registered-read memory
`timescale 1ns / 1ps

module nbss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/nested_break_site_stack_core.sv @@
// top level of the nested break-site stack
`timescale 1ns / 1ps
//
// usage
// - in_valid/in_ready/in_data carry commands (enter, record, exit) with a
//   break position; out_valid/out_ready/out_data carry result items
// - enter, record, an exit at depth zero and the unused code each give one
//   result; a transfer is registered and its result shows in out_data the
//   cycle after, so these run at one item per cycle while out_ready is high
// - exit of a level with n recorded sites gives n results, one per cycle
//   while out_ready is high, the last one flagged; the input stays closed
//   while the sequencer reads the sites through the registered read of the
//   site memory and the read slot, until it finds the slot drained; the new
//   top's count reloads from the count memory meanwhile (an empty level
//   closes the input as well)
// - sites sit in a MAX_LEVELS x MAX_SITES memory, the counts of the levels
//   below the top in a second memory; the top count lives in a register
// - a stalled receiver holds the output register; the read data of the
//   site memory waits in place and no new read is issued until it moves
// - reset (rst_n low, synchronous) closes every level; the site memory is
//   not cleared, since only sites written since their level opened are read
//

module nested_break_site_stack_core #(
  parameter int unsigned MAX_LEVELS = 8,
  parameter int unsigned MAX_SITES  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nbss_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nbss_pkg::out_item_t out_data
);

  localparam int unsigned ENTRIES = MAX_LEVELS * MAX_SITES;
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned DW = $clog2(MAX_LEVELS + 1);
  localparam int unsigned CW = $clog2(MAX_SITES + 1);

  typedef enum logic {
    S_IDLE,
    S_EXIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [DW-1:0]       depth_r, depth_nxt;
  logic [CW-1:0]       top_count_r, top_count_nxt;
  logic [AW-1:0]       top_base_r, top_base_nxt;
  logic [AW-1:0]       ex_base_r, ex_base_nxt;
  logic [CW-1:0]       ex_cnt_r, ex_cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic                rd_last_r, rd_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  nbss_pkg::out_item_t out_data_r, out_data_nxt;

  // memory ports
  logic                       st_wr_en, st_rd_en;
  logic [AW-1:0]              st_wr_addr, st_rd_addr;
  logic [nbss_pkg::SITE_W-1:0] st_rd_data;
  logic                       cm_wr_en, cm_rd_en;
  logic [LW-1:0]              cm_wr_addr, cm_rd_addr;
  logic [CW-1:0]              cm_rd_data;

  logic          accept, out_free, move, issue;
  logic [DW-1:0] dm1, dm2, new_depth;
  nbss_pkg::cmd_t cmd;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign cmd      = nbss_pkg::cmd_t'(in_data.command);

  assign dm1 = depth_r - DW'(1);
  assign dm2 = depth_r - DW'(2);

  // read data waiting in the slot moves into the output register when free
  assign move  = rd_v_r && out_free;
  assign issue = (state_r == S_EXIT) && (idx_r != ex_cnt_r) && (!rd_v_r || move);

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    top_count_nxt = top_count_r;
    top_base_nxt  = top_base_r;
    ex_base_nxt   = ex_base_r;
    ex_cnt_nxt    = ex_cnt_r;
    idx_nxt       = idx_r;
    rd_v_nxt      = rd_v_r;
    rd_last_nxt   = rd_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    new_depth     = depth_r;

    st_wr_en   = 1'b0;
    st_wr_addr = top_base_r + AW'(top_count_r);
    st_rd_en   = 1'b0;
    st_rd_addr = ex_base_r + AW'(idx_r);
    cm_wr_en   = 1'b0;
    cm_wr_addr = dm1[LW-1:0];
    cm_rd_en   = 1'b0;
    cm_rd_addr = dm2[LW-1:0];

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      // default single result, fields patched per command
      out_valid_nxt           = 1'b1;
      out_data_nxt.status     = nbss_pkg::ST_OK;
      out_data_nxt.site_valid = 1'b0;
      out_data_nxt.patch_site = '0;
      out_data_nxt.last       = 1'b1;
      case (cmd)
        nbss_pkg::CMD_ENTER: begin
          if (depth_r == DW'(MAX_LEVELS)) begin
            out_data_nxt.status = nbss_pkg::ST_FULL;
          end else begin
            // park the current top count below the new level
            cm_wr_en      = (depth_r != '0);
            top_count_nxt = '0;
            top_base_nxt  = (depth_r == '0) ? '0 : top_base_r + AW'(MAX_SITES);
            new_depth     = depth_r + DW'(1);
          end
        end
        nbss_pkg::CMD_RECORD: begin
          if (depth_r == '0) begin
            out_data_nxt.status = nbss_pkg::ST_NO_LEVEL;
          end else if (top_count_r == CW'(MAX_SITES)) begin
            out_data_nxt.status = nbss_pkg::ST_LIST_FULL;
          end else begin
            st_wr_en      = 1'b1;
            top_count_nxt = top_count_r + CW'(1);
          end
        end
        nbss_pkg::CMD_EXIT: begin
          if (depth_r == '0) begin
            out_data_nxt.status = nbss_pkg::ST_NO_LEVEL;
          end else begin
            // pop now; the new top count comes back from the count memory
            cm_rd_en     = 1'b1;
            new_depth    = dm1;
            top_base_nxt = top_base_r - AW'(MAX_SITES);
            ex_base_nxt  = top_base_r;
            ex_cnt_nxt   = top_count_r;
            idx_nxt      = '0;
            state_nxt    = S_EXIT;
            // a non-empty list emits from the sequencer instead
            out_valid_nxt = (top_count_r == '0);
          end
        end
        default: begin
        end
      endcase
      depth_nxt                = new_depth;
      out_data_nxt.in_loop     = (new_depth != '0);
      out_data_nxt.level_depth = nbss_pkg::DEPTH_W'(new_depth);
    end

    if (state_r == S_EXIT) begin
      top_count_nxt = (depth_r == '0) ? '0 : cm_rd_data;
      if (move) begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.status      = nbss_pkg::ST_OK;
        out_data_nxt.site_valid  = 1'b1;
        out_data_nxt.patch_site  = st_rd_data;
        out_data_nxt.last        = rd_last_r;
        out_data_nxt.in_loop     = (depth_r != '0);
        out_data_nxt.level_depth = nbss_pkg::DEPTH_W'(depth_r);
        rd_v_nxt                 = 1'b0;
      end
      if (issue) begin
        st_rd_en    = 1'b1;
        idx_nxt     = idx_r + CW'(1);
        rd_v_nxt    = 1'b1;
        rd_last_nxt = ((idx_r + CW'(1)) == ex_cnt_r);
      end
      if ((idx_r == ex_cnt_r) && !rd_v_r) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      top_count_r <= '0;
      top_base_r  <= '0;
      idx_r       <= '0;
      ex_cnt_r    <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      top_count_r <= top_count_nxt;
      top_base_r  <= top_base_nxt;
      idx_r       <= idx_nxt;
      ex_cnt_r    <= ex_cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ex_base_r  <= ex_base_nxt;
    rd_last_r  <= rd_last_nxt;
    out_data_r <= out_data_nxt;
  end

  // recorded sites, one row of MAX_SITES per level
  nbss_ram #(
    .WIDTH (nbss_pkg::SITE_W),
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_site_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (in_data.break_position),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // counts of the levels under the top
  nbss_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_LEVELS),
    .AW    (LW)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (cm_wr_en),
    .wr_addr (cm_wr_addr),
    .wr_data (top_count_r),
    .rd_en   (cm_rd_en),
    .rd_addr (cm_rd_addr),
    .rd_data (cm_rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_LEVELS))
    else $error("open level count beyond limit");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (top_count_r <= CW'(MAX_SITES)))
    else $error("top site count beyond limit");

  a_slot_in_exit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == S_EXIT))
    else $error("read slot busy outside exit");

  a_exit_enters_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd == nbss_pkg::CMD_EXIT) && (depth_r != '0))
      |=> (state_r == S_EXIT) && (depth_r == $past(dm1)))
    else $error("exit did not pop and start the sequencer");

endmodule
